### rtl/flm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flm_pkg
// Shared widths, defaults and request kinds for the fixed latency line memory.
// ----------------------------------------------------------------------------
package flm_pkg;

    localparam int DATA_W              = 32;
    localparam int MAX_LINE_WORDS      = 4;
    localparam int REQ_W               = 8;
    localparam int LATENCY_W           = 8;
    localparam int NUM_LINES_DEFAULT   = 64;
    localparam int LINE_WORDS_DEFAULT  = 4;

    localparam logic [LATENCY_W-1:0] LATENCY_RESET = 8'd4;

    typedef enum logic [2:0] {
        KIND_IDLE  = 3'b001,
        KIND_LOAD  = 3'b010,
        KIND_STORE = 3'b100
    } kind_t;

endpackage

### rtl/fixed_latency_line_memory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_latency_line_memory
// Line memory with a fixed access latency counted in matching request
// attempts; mismatching attempts are refused with a stall result.
// Path: the result of an item passes the registered line RAM read and then
//   the output register.
// Throughput: one item per cycle while out_stall is low and no reset sweep runs.
// Reset: the line RAM is cleared one line per cycle, through all NUM_LINES lines;
//   no item is accepted during that sweep, configuration writes are.
// ----------------------------------------------------------------------------
module fixed_latency_line_memory #(
    parameter int NUM_LINES  = flm_pkg::NUM_LINES_DEFAULT,
    parameter int LINE_WORDS = flm_pkg::LINE_WORDS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [flm_pkg::LATENCY_W-1:0]   cfg_data,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [flm_pkg::REQ_W-1:0]       requester,
    input  logic signed [31:0]              address,
    input  logic [flm_pkg::DATA_W-1:0]      store_word0,
    input  logic [flm_pkg::DATA_W-1:0]      store_word1,
    input  logic [flm_pkg::DATA_W-1:0]      store_word2,
    input  logic [flm_pkg::DATA_W-1:0]      store_word3,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            stall_res,
    output logic [flm_pkg::DATA_W-1:0]      load_word0,
    output logic [flm_pkg::DATA_W-1:0]      load_word1,
    output logic [flm_pkg::DATA_W-1:0]      load_word2,
    output logic [flm_pkg::DATA_W-1:0]      load_word3
);

    localparam int TOTAL_WORDS = NUM_LINES * LINE_WORDS;
    localparam int WADDR_W     = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int WORD_SEL_W  = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 0;
    localparam int LINE_IDX_W  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
    localparam int LINE_W      = LINE_WORDS * flm_pkg::DATA_W;

    localparam logic [WADDR_W-1:0]    WADDR_MASK = WADDR_W'(TOTAL_WORDS - 1);
    localparam logic [LINE_IDX_W-1:0] LINE_MASK  = LINE_IDX_W'(NUM_LINES - 1);
    localparam logic [LINE_IDX_W-1:0] LINE_LAST  = LINE_IDX_W'(NUM_LINES - 1);

    logic [flm_pkg::LATENCY_W-1:0] latency_reg;

    flm_pkg::kind_t                kind_reg,      kind_next;
    logic [flm_pkg::REQ_W-1:0]     requester_reg, requester_next;
    logic [WADDR_W-1:0]            addr_reg,      addr_next;
    logic [flm_pkg::LATENCY_W-1:0] count_reg,     count_next;
    logic [LINE_W-1:0]             line_reg,      line_next;

    logic                          clear_busy_reg, clear_busy_next;
    logic [LINE_IDX_W-1:0]         clear_idx_reg,  clear_idx_next;

    logic                          s1_valid_reg,  s1_valid_next;
    logic                          s1_stall_reg,  s1_stall_next;
    logic                          s1_load_reg,   s1_load_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          stall_res_reg;
    logic [flm_pkg::DATA_W-1:0]    load_word_reg [flm_pkg::MAX_LINE_WORDS];

    logic [flm_pkg::DATA_W-1:0]    store_words [flm_pkg::MAX_LINE_WORDS];
    logic [flm_pkg::DATA_W-1:0]    load_words  [flm_pkg::MAX_LINE_WORDS];
    logic [LINE_W-1:0]             in_line;

    flm_pkg::kind_t                in_kind;
    flm_pkg::kind_t                eff_kind;
    logic [flm_pkg::REQ_W-1:0]     eff_requester;
    logic [WADDR_W-1:0]            eff_addr;
    logic [flm_pkg::LATENCY_W-1:0] eff_count;
    logic [LINE_W-1:0]             eff_line;

    logic                          idle;
    logic                          accept;
    logic                          match;
    logic                          done;
    logic                          out_load;
    logic [WADDR_W-1:0]            wrapped;
    logic [WADDR_W-1:0]            line_wide;
    logic [LINE_IDX_W-1:0]         line_idx;

    logic                          ram_we;
    logic [LINE_IDX_W-1:0]         ram_waddr;
    logic [LINE_W-1:0]             ram_wdata;
    logic [LINE_W-1:0]             ram_rdata;

    assign store_words[0] = store_word0;
    assign store_words[1] = store_word1;
    assign store_words[2] = store_word2;
    assign store_words[3] = store_word3;

    generate
        for (genvar w = 0; w < flm_pkg::MAX_LINE_WORDS; w++)
        begin : g_words
            if (w < LINE_WORDS)
            begin : g_used
                assign in_line[w*flm_pkg::DATA_W +: flm_pkg::DATA_W] = store_words[w];
                assign load_words[w] = s1_load_reg
                    ? ram_rdata[w*flm_pkg::DATA_W +: flm_pkg::DATA_W]
                    : '0;
            end
            else
            begin : g_unused
                assign load_words[w] = '0;
            end
        end
    endgenerate

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg <= flm_pkg::LATENCY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            latency_reg <= cfg_data;
        end
    end

    // Request decode and matching against the pending request
    assign wrapped   = address[WADDR_W-1:0] & WADDR_MASK;
    assign line_wide = wrapped >> WORD_SEL_W;
    assign line_idx  = line_wide[LINE_IDX_W-1:0] & LINE_MASK;
    assign in_kind   = mode ? flm_pkg::KIND_STORE : flm_pkg::KIND_LOAD;
    assign idle      = (kind_reg == flm_pkg::KIND_IDLE);

    assign eff_kind      = idle ? in_kind     : kind_reg;
    assign eff_requester = idle ? requester   : requester_reg;
    assign eff_addr      = idle ? wrapped     : addr_reg;
    assign eff_count     = idle ? latency_reg : count_reg;
    assign eff_line      = idle ? in_line     : line_reg;

    assign match = (eff_requester == requester) && (eff_kind == in_kind)
                   && (eff_addr == wrapped);
    assign done  = match && (eff_count <= flm_pkg::LATENCY_W'(1));

    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clear_busy_reg || (s1_valid_reg && !out_load);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        kind_next      = kind_reg;
        requester_next = requester_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        line_next      = line_reg;
        if (accept)
        begin
            if (done)
            begin
                kind_next      = flm_pkg::KIND_IDLE;
                requester_next = '0;
                addr_next      = '0;
                count_next     = '0;
            end
            else if (match)
            begin
                kind_next      = eff_kind;
                requester_next = eff_requester;
                addr_next      = eff_addr;
                count_next     = eff_count - flm_pkg::LATENCY_W'(1);
                line_next      = eff_line;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= flm_pkg::KIND_IDLE;
            requester_reg <= '0;
            addr_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            kind_reg      <= kind_next;
            requester_reg <= requester_next;
            addr_reg      <= addr_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

    // Clear the line RAM after reset
    always_comb
    begin
        clear_busy_next = clear_busy_reg;
        clear_idx_next  = clear_idx_reg;
        if (clear_busy_reg)
        begin
            clear_idx_next = clear_idx_reg + LINE_IDX_W'(1);
            if (clear_idx_reg == LINE_LAST)
            begin
                clear_busy_next = 1'b0;
                clear_idx_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_idx_reg  <= '0;
        end
        else
        begin
            clear_busy_reg <= clear_busy_next;
            clear_idx_reg  <= clear_idx_next;
        end
    end

    assign ram_we    = clear_busy_reg || (accept && done && (eff_kind == flm_pkg::KIND_STORE));
    assign ram_waddr = clear_busy_reg ? clear_idx_reg : line_idx;
    assign ram_wdata = clear_busy_reg ? '0 : eff_line;

    flm_ram #(
        .WIDTH (LINE_W),
        .DEPTH (NUM_LINES)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (line_idx),
        .rdata (ram_rdata)
    );

    // Read stage and output register
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_stall_next = s1_stall_reg;
        s1_load_next  = s1_load_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_stall_next = !done;
            s1_load_next  = done && (eff_kind == flm_pkg::KIND_LOAD);
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_stall_reg <= s1_stall_next;
        s1_load_reg  <= s1_load_next;
        if (out_load)
        begin
            stall_res_reg <= s1_stall_reg;
            for (int w = 0; w < flm_pkg::MAX_LINE_WORDS; w++)
            begin
                load_word_reg[w] <= load_words[w];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign stall_res  = stall_res_reg;
    assign load_word0 = load_word_reg[0];
    assign load_word1 = load_word_reg[1];
    assign load_word2 = load_word_reg[2];
    assign load_word3 = load_word_reg[3];

endmodule

### rtl/flm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flm_ram
// Generic synchronous RAM with one write port and one registered, enabled read port.
// ----------------------------------------------------------------------------
module flm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
